// ----- sv/lpht_pkg.sv -----
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned MOD_STEPS = 16;
  localparam int unsigned MSTEP_W   = $clog2(MOD_STEPS);

  localparam logic [KEY_W-1:0]  RESERVED_KEY = 32'h7fff_ffff;
  localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(CAPACITY);

  typedef enum logic [1:0] {
    KIND_UPSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_EV,
    S_ACT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              key_we;
    logic              val_we;
    logic              mark_we;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  value;
    mark_e             mark;
  } slot_wr_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    mark_e            mark;
  } slot_rd_t;

endpackage

// ----- sv/lpht_mod.sv -----
// Multi-cycle remainder unit: key modulo table size, two bits a cycle.
`timescale 1ns / 1ps
module lpht_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lpht_pkg::KEY_W-1:0]    dividend_i,
  input  logic [lpht_pkg::SIZE_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [lpht_pkg::ADDR_W-1:0]   rem_o
);
  import lpht_pkg::*;

  logic [KEY_W-1:0]   dv_q;
  logic [ADDR_W-1:0]  r_q;
  logic [MSTEP_W-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [SIZE_W-1:0]  t1, t2;
  logic [ADDR_W-1:0]  r1, r2;

  // Two restoring steps; the partial remainder stays below the divisor.
  always_comb begin
    t1 = {r_q, dv_q[KEY_W-1]};
    if (t1 >= divisor_i) t1 = t1 - divisor_i;
    r1 = t1[ADDR_W-1:0];
    t2 = {r1, dv_q[KEY_W-2]};
    if (t2 >= divisor_i) t2 = t2 - divisor_i;
    r2 = t2[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MSTEP_W'(1);
        if (cnt_q == MSTEP_W'(MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q <= dividend_i;
      r_q  <= '0;
    end else if (busy_q) begin
      dv_q <= {dv_q[KEY_W-3:0], 2'b00};
      r_q  <= r2;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ----- sv/lpht_store.sv -----
// Slot store: key, value and mark memories with one registered read port.
`timescale 1ns / 1ps
module lpht_store (
  input  logic                        clk_i,
  input  logic [lpht_pkg::ADDR_W-1:0] rd_addr_i,
  input  lpht_pkg::slot_wr_t          wr_i,
  output lpht_pkg::slot_rd_t          rd_o
);
  import lpht_pkg::*;

  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [KEY_W-1:0] val_mem  [CAPACITY];
  mark_e            mark_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we)  key_mem[wr_i.addr]  <= wr_i.key;
    if (wr_i.val_we)  val_mem[wr_i.addr]  <= wr_i.value;
    if (wr_i.mark_we) mark_mem[wr_i.addr] <= wr_i.mark;
    rd_o.key   <= key_mem[rd_addr_i];
    rd_o.value <= val_mem[rd_addr_i];
    rd_o.mark  <= mark_mem[rd_addr_i];
  end

endmodule

// ----- sv/linear_probe_hash_table.sv -----
// A probe chain holds 1 up to table_size slots; one item is in flight at a time.
// A finished result waits in the output register while the next item is taken.
// Reset, and every table_size write, run a mark clearing pass over all CAPACITY slots;
// no item is accepted during it. After reset table_size is 1024 and the count is zero.
`timescale 1ns / 1ps
module linear_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg: table_size[10:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: key[31:0], new_value[63:32]
  input  logic [63:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], found_value[33:2], replaced[34], occupied_count[45:35], zero[47:46]
  output logic [47:0] m_axis_tdata
);
  import lpht_pkg::*;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, cnt_q, p_q;
  logic [ADDR_W-1:0] clr_q, j_q, free_q, j_next, rd_addr, mod_rem;
  kind_e             kind_q;
  logic [KEY_W-1:0]  key_q, val_q, hitval_q, found_q;
  logic              hit_q, have_free_q, replaced_q;
  status_e           status_q;
  logic              out_valid_q;
  logic [47:0]       out_data_q;
  logic              cfg_fire, in_fire, reject, mod_done;
  logic              is_empty, is_hit, is_tomb, last_probe, stop, out_load;
  logic [SIZE_W-1:0] size_new;
  slot_wr_t          wr;
  slot_rd_t          rd;

  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign reject        = (s_axis_tdata[KEY_W-1:0] == RESERVED_KEY) ||
                         ((s_axis_tuser != KIND_UPSERT) && (s_axis_tuser != KIND_SEARCH) &&
                          (s_axis_tuser != KIND_DELETE));

  // Clamp the written size into 1..CAPACITY.
  always_comb begin
    size_new = cfg_data_i;
    if (size_new == '0) size_new = SIZE_W'(1);
    else if (size_new > SIZE_MAX) size_new = SIZE_MAX;
  end

  lpht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && !reject),
    .dividend_i (s_axis_tdata[KEY_W-1:0]),
    .divisor_i  (size_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  lpht_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  assign is_empty   = (rd.mark == MARK_EMPTY);
  assign is_hit     = (rd.mark == MARK_LIVE) && (rd.key == key_q);
  assign is_tomb    = (rd.mark == MARK_TOMB);
  assign last_probe = ((p_q + SIZE_W'(1)) == size_q);
  assign stop       = is_empty || is_hit || last_probe;
  assign j_next     = (({1'b0, j_q} + SIZE_W'(1)) == size_q) ? '0 : j_q + ADDR_W'(1);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    rd_addr = j_q;
    wr      = '{key_we: 1'b0, val_we: 1'b0, mark_we: 1'b0, addr: j_q,
                key: key_q, value: val_q, mark: MARK_EMPTY};
    unique case (state_q)
      S_CLEAR: begin
        wr.mark_we = 1'b1;
        wr.addr    = clr_q;
        wr.mark    = MARK_EMPTY;
        if (clr_q == ADDR_W'(CAPACITY - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_d = reject ? S_DONE : S_MOD;
      end
      S_MOD: begin
        if (mod_done) state_d = S_RD;
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        if (stop) state_d = S_ACT;
        else      rd_addr = j_next;
      end
      S_ACT: begin
        state_d = S_DONE;
        unique case (kind_q)
          KIND_UPSERT: begin
            if (hit_q) begin
              wr.val_we = 1'b1;
            end else if (have_free_q) begin
              wr.key_we  = 1'b1;
              wr.val_we  = 1'b1;
              wr.mark_we = 1'b1;
              wr.addr    = free_q;
              wr.mark    = MARK_LIVE;
            end
          end
          KIND_DELETE: begin
            if (hit_q) begin
              wr.val_we  = 1'b1;
              wr.value   = '0;
              wr.mark_we = 1'b1;
              wr.mark    = MARK_TOMB;
            end
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    // A size write restarts the clearing pass.
    if (cfg_fire) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_MAX;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        size_q <= size_new;
        cnt_q  <= '0;
        clr_q  <= '0;
      end else if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end else if (state_q == S_ACT) begin
        if (kind_q == KIND_UPSERT && !hit_q && have_free_q) cnt_q <= cnt_q + SIZE_W'(1);
        if (kind_q == KIND_DELETE && hit_q)                 cnt_q <= cnt_q - SIZE_W'(1);
      end
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        kind_q      <= kind_e'(s_axis_tuser);
        key_q       <= s_axis_tdata[KEY_W-1:0];
        val_q       <= s_axis_tdata[2*KEY_W-1:KEY_W];
        status_q    <= reject ? ST_REJECT : ST_OK;
        found_q     <= '0;
        replaced_q  <= 1'b0;
        hit_q       <= 1'b0;
        have_free_q <= 1'b0;
      end
      S_MOD: begin
        j_q <= mod_rem;
        p_q <= '0;
      end
      S_EV: begin
        if ((is_empty || is_tomb) && !have_free_q) begin
          have_free_q <= 1'b1;
          free_q      <= j_q;
        end
        if (is_hit) begin
          hit_q    <= 1'b1;
          hitval_q <= rd.value;
        end
        if (!stop) begin
          j_q <= j_next;
          p_q <= p_q + SIZE_W'(1);
        end
      end
      S_ACT: begin
        unique case (kind_q)
          KIND_UPSERT: begin
            if (hit_q)             replaced_q <= 1'b1;
            else if (!have_free_q) status_q   <= ST_FULL;
          end
          KIND_SEARCH: begin
            if (hit_q) found_q  <= hitval_q;
            else       status_q <= ST_MISS;
          end
          KIND_DELETE: begin
            if (!hit_q) status_q <= ST_MISS;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (out_load) out_data_q <= {2'b00, cnt_q, replaced_q, found_q, status_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the linear probing hash table: directed and random requests.
module tb;
  import lpht_pkg::*;

  localparam logic [1:0]  KIND_BAD     = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef struct {
    status_e     status;
    logic [31:0] found;
    logic        replaced;
    logic [10:0] occupied;
  } reply_t;

  // Mirror of the slot store plus the queue of replies still owed by the block.
  class table_tracker;
    logic [KEY_W-1:0] keys[CAPACITY];
    logic [KEY_W-1:0] vals[CAPACITY];
    mark_e            marks[CAPACITY];
    logic [10:0]      live_count;
    int unsigned      slots;
    reply_t           pending_replies[$];
    int               errors;
    int               noted;
    int               checked;
    int               seen[4];

    function new();
      errors = 0;
      noted = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
      resize(SIZE_MAX);
    endfunction

    // Clamp the written size and wipe every slot.
    function void resize(logic [10:0] word);
      if (word == 0) begin
        slots = 1;
      end else if (word > CAPACITY) begin
        slots = CAPACITY;
      end else begin
        slots = word;
      end
      foreach (marks[i]) marks[i] = MARK_EMPTY;
      live_count = '0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
      reply_t      r;
      int unsigned home;
      int unsigned j;
      int unsigned hole;
      bit          hit;
      bit          have_hole;
      r.status = ST_OK;
      r.found = '0;
      r.replaced = 1'b0;
      hit = 1'b0;
      have_hole = 1'b0;
      hole = 0;
      j = 0;
      noted++;
      if (key == RESERVED_KEY || kind == KIND_BAD) begin
        r.status = ST_REJECT;
      end else begin
        home = key % slots;
        for (int unsigned p = 0; p < slots; p++) begin
          j = home + p;
          if (j >= slots) j -= slots;
          if (marks[j] == MARK_EMPTY) begin
            if (!have_hole) begin
              have_hole = 1'b1;
              hole = j;
            end
            break;
          end
          if (marks[j] == MARK_LIVE && keys[j] == key) begin
            hit = 1'b1;
            break;
          end
          // remember the first tombstone for reuse
          if (marks[j] == MARK_TOMB && !have_hole) begin
            have_hole = 1'b1;
            hole = j;
          end
        end
        case (kind)
          KIND_UPSERT: begin
            if (hit) begin
              vals[j] = value;
              r.replaced = 1'b1;
            end else if (have_hole) begin
              keys[hole] = key;
              vals[hole] = value;
              marks[hole] = MARK_LIVE;
              live_count = live_count + 1'b1;
            end else begin
              r.status = ST_FULL;
            end
          end
          KIND_SEARCH: begin
            if (hit) begin
              r.found = vals[j];
            end else begin
              r.status = ST_MISS;
            end
          end
          default: begin
            if (hit) begin
              marks[j] = MARK_TOMB;
              vals[j] = '0;
              live_count = live_count - 1'b1;
            end else begin
              r.status = ST_MISS;
            end
          end
        endcase
      end
      r.occupied = live_count;
      seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_reply(logic [47:0] word);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", word));
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (word[1:0] !== want.status)
        report($sformatf("status %0d, expected %0d", word[1:0], want.status));
      if (word[33:2] !== want.found)
        report($sformatf("found_value %h, expected %h", word[33:2], want.found));
      if (word[34] !== want.replaced)
        report($sformatf("replaced %b, expected %b", word[34], want.replaced));
      if (word[45:35] !== want.occupied)
        report($sformatf("occupied_count %0d, expected %0d", word[45:35], want.occupied));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  table_tracker tracker = new();
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  cycles = 0;
  int           size_writes = 0;

  linear_probe_hash_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted items, then pick the next ready level.
  initial begin
    int burst;
    int long_left;
    burst = 0;
    long_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.check_reply(m_axis_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Leave valid high on return so the next item follows without a bubble.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] key,
                           input logic [31:0] value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(kind, key, value);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [10:0] word);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.resize(word);
    size_writes++;
  endtask

  // Draw keys from a small pool so hits, collisions and full tables show up.
  task automatic random_phase(input logic [10:0] size_word, input int count,
                              input int hold_at, input int pause_at);
    logic [31:0] pool[16];
    logic [1:0]  kind;
    logic [31:0] key;
    int          roll;
    write_size(size_word);
    foreach (pool[i]) begin
      case ($urandom_range(0, 3))
        0: pool[i] = $urandom();
        1: pool[i] = $urandom_range(0, 63);
        2: pool[i] = 32'h8000_0000 + $urandom_range(0, 63);
        default: pool[i] = ~32'($urandom_range(0, 63));
      endcase
    end
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) wait_drained();
      roll = $urandom_range(0, 99);
      key = pool[$urandom_range(0, 15)];
      if (roll < 4) begin
        key = RESERVED_KEY;
      end else if (roll < 10) begin
        key = $urandom();
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        kind = KIND_UPSERT;
      end else if (roll < 72) begin
        kind = KIND_SEARCH;
      end else if (roll < 96) begin
        kind = KIND_DELETE;
      end else begin
        kind = KIND_BAD;
      end
      send_item(kind, key, $urandom());
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size: collisions at slot zero, replace, tombstone skip and reuse.
    send_item(KIND_UPSERT, 32'h0000_0000, 32'h7fff_ffff);
    send_item(KIND_UPSERT, 32'd1024,      32'h8000_0000);
    send_item(KIND_UPSERT, 32'hffff_ffff, 32'h0000_0000);
    send_item(KIND_UPSERT, 32'h8000_0000, 32'h0000_0001);
    send_item(KIND_SEARCH, 32'd1024,      32'hffff_ffff);
    send_item(KIND_UPSERT, 32'h0000_0000, 32'hffff_ffff);
    send_item(KIND_DELETE, 32'h0000_0000, 32'h0);
    send_item(KIND_SEARCH, 32'h8000_0000, 32'h0);
    send_item(KIND_UPSERT, 32'd2048,      32'd7);
    send_item(KIND_DELETE, 32'd12345,     32'h0);
    send_item(KIND_SEARCH, 32'h7fff_fffe, 32'h0);
    send_item(KIND_UPSERT, RESERVED_KEY,  32'd9);
    send_item(KIND_SEARCH, RESERVED_KEY,  32'h0);
    send_item(KIND_DELETE, RESERVED_KEY,  32'h0);
    send_item(KIND_BAD,    32'd5,         32'd5);

    // Two slots: fill, overflow, miss on a full chain, free and reuse.
    write_size(11'd2);
    send_item(KIND_UPSERT, 32'd4, 32'd1);
    send_item(KIND_UPSERT, 32'd6, 32'd2);
    send_item(KIND_UPSERT, 32'd8, 32'd3);
    send_item(KIND_SEARCH, 32'd9, 32'h0);
    send_item(KIND_DELETE, 32'd4, 32'h0);
    send_item(KIND_UPSERT, 32'd8, 32'd3);
    send_item(KIND_SEARCH, 32'd6, 32'h0);

    random_phase(11'd7,    60, -1, -1);
    random_phase(11'd1,    25, -1, -1);
    random_phase(11'd0,    25, -1, -1);
    random_phase(11'd16,   60, 20, -1);
    random_phase(11'd2047, 50, -1, 25);
    random_phase(11'd3,    40, -1, -1);
    random_phase(11'd100,  50, -1, -1);
    random_phase(11'd33,   50, -1, -1);
    calm = 1'b1;
    random_phase(11'd1024, 60, -1, -1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests over %0d table size writes; %0d results checked.",
             tracker.noted, size_writes, tracker.checked);
    $display("Outcomes: found/done %0d, miss %0d, full %0d, rejected %0d.",
             tracker.seen[ST_OK], tracker.seen[ST_MISS], tracker.seen[ST_FULL],
             tracker.seen[ST_REJECT]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- linear_probe_hash_table.f -----
sv/lpht_pkg.sv
sv/lpht_mod.sv
sv/lpht_store.sv
sv/linear_probe_hash_table.sv
verif/tb.sv
